// ----- sv/ssd_scan_pkg.sv -----
// Package for the seven-segment decimal display scanner.
// Holds the sizes, request codes, sequencer states and the segment and BCD helper functions.
// No dependencies.
package ssd_scan_pkg;

	localparam int BUF_DEPTH  = 8;
	localparam int DIGITS     = 8;
	localparam int NDIG       = (DIGITS > BUF_DEPTH) ? BUF_DEPTH : ((DIGITS < 1) ? 1 : DIGITS);
	localparam int IDX_W      = $clog2(BUF_DEPTH);
	localparam int BIN_W      = 32;
	localparam int BCD_W      = 4 * BUF_DEPTH;
	localparam int CNT_W      = $clog2(BIN_W);
	localparam int OUT_W      = ((IDX_W + 8 + 7) / 8) * 8;

	localparam logic [7:0] BLANK_SEG = 8'h00;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_FILL
	} state_t;

	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'h3f;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5b;
			4'd3: seg = 8'h4f;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6d;
			4'd6: seg = 8'h7d;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7f;
			4'd9: seg = 8'h6f;
			default: seg = BLANK_SEG;
		endcase
		return seg;
	endfunction

	// add 3 to every BCD digit of 5 or more; carries above the top digit are dropped
	function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		res = bcd;
		for (int i = 0; i < BUF_DEPTH; i++) begin
			if (bcd[4*i +: 4] >= 4'd5)
				res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
		end
		return res;
	endfunction

endpackage

// ----- sv/seven_segment_decimal_display_scanner.sv -----
// Seven-segment decimal display scanner, top level.
// Shift-add-3 binary to decimal converter, digit fill sequencer, segment buffer and scan output.
// Depends on ssd_scan_pkg.
//
// Usage:
//   Slave stream s_*: one beat per request. s_tuser selects the kind
//   (0 = load number, 1 = scan tick); s_tdata carries the 32-bit number, used on load only.
//   Master stream m_*: one beat per scan tick with the digit select and its segment byte.
//   A load gives no beat on m_*.
// Sequencing:
//   Load: conversion through the single shift-add-3 unit (ST_CONV), then fill
//   (ST_FILL) writing one buffer entry per cycle; s_tready stays low until back in ST_IDLE.
//   Tick: result registered on the accepting edge; one tick per cycle while no load
//   is in progress and the receiver keeps m_tready high.
// Reset: arst_n clears the segment buffer to blank, the scan index to digit 0 and
//   the output valid.
// Stall: while a result beat waits on m_tready low, s_tready is held low; the
//   result stays on m_tdata until taken.
module seven_segment_decimal_display_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ssd_scan_pkg::BIN_W-1:0] s_tdata,   // [31:0] number_value
	input  logic                           s_tuser,   // [0] req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ssd_scan_pkg::OUT_W-1:0] m_tdata    // [2:0] digit_select, [10:3] segment_bits
);

	localparam int IDX_W = ssd_scan_pkg::IDX_W;
	localparam int BCD_W = ssd_scan_pkg::BCD_W;
	localparam int BIN_W = ssd_scan_pkg::BIN_W;
	localparam int CNT_W = ssd_scan_pkg::CNT_W;

	ssd_scan_pkg::state_t state_q, state_d;

	logic [7:0]       seg_buf_q [ssd_scan_pkg::BUF_DEPTH];
	logic [IDX_W-1:0] scan_idx_q;
	logic [BIN_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] fill_idx_q;
	logic             seen_q;
	logic             out_valid_q;
	logic [IDX_W-1:0] out_sel_q;
	logic [7:0]       out_seg_q;

	logic             out_free;
	logic             in_beat;
	logic             load_beat;
	logic             tick_beat;
	logic             conv_done;
	logic             fill_done;
	logic [3:0]       fill_digit;
	logic             fill_in_range;
	logic             fill_show;
	logic [7:0]       fill_seg;
	logic [BCD_W-1:0] bcd_adj;

	assign out_free  = !out_valid_q || m_tready;
	assign in_beat   = s_tvalid && s_tready;
	assign load_beat = in_beat && (s_tuser == ssd_scan_pkg::REQ_LOAD);
	assign tick_beat = in_beat && (s_tuser == ssd_scan_pkg::REQ_TICK);
	assign conv_done = (cnt_q == CNT_W'(BIN_W - 1));
	assign fill_done = (fill_idx_q == '0);
	assign bcd_adj   = ssd_scan_pkg::dd_adjust(bcd_q);

	assign fill_digit    = bcd_q[4*fill_idx_q +: 4];
	assign fill_in_range = ({1'b0, fill_idx_q} < (IDX_W+1)'(ssd_scan_pkg::NDIG));
	assign fill_show     = fill_in_range && (seen_q || (fill_digit != 4'd0) || fill_done);
	assign fill_seg      = fill_show ? ssd_scan_pkg::seg_of(fill_digit) : ssd_scan_pkg::BLANK_SEG;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssd_scan_pkg::ST_IDLE: begin
				if (load_beat)
					state_d = ssd_scan_pkg::ST_CONV;
			end
			ssd_scan_pkg::ST_CONV: begin
				if (conv_done)
					state_d = ssd_scan_pkg::ST_FILL;
			end
			ssd_scan_pkg::ST_FILL: begin
				if (fill_done)
					state_d = ssd_scan_pkg::ST_IDLE;
			end
			default: state_d = ssd_scan_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		case (state_q)
			ssd_scan_pkg::ST_IDLE: s_tready = out_free;
			default:               s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssd_scan_pkg::ST_IDLE;
			cnt_q       <= '0;
			fill_idx_q  <= '0;
			seen_q      <= 1'b0;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ssd_scan_pkg::BUF_DEPTH; i++)
				seg_buf_q[i] <= ssd_scan_pkg::BLANK_SEG;
		end else begin
			state_q <= state_d;
			if (tick_beat) begin
				out_valid_q <= 1'b1;
				scan_idx_q  <= scan_idx_q + 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ssd_scan_pkg::ST_IDLE: begin
					cnt_q      <= '0;
					fill_idx_q <= IDX_W'(ssd_scan_pkg::BUF_DEPTH - 1);
					seen_q     <= 1'b0;
				end
				ssd_scan_pkg::ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
				end
				ssd_scan_pkg::ST_FILL: begin
					seg_buf_q[fill_idx_q] <= fill_seg;
					fill_idx_q            <= fill_idx_q - 1'b1;
					if (fill_in_range && (fill_digit != 4'd0))
						seen_q <= 1'b1;
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// conversion datapath and output registers, no reset
	always_ff @(posedge clk) begin
		if (load_beat) begin
			bin_q <= s_tdata;
			bcd_q <= '0;
		end else if (state_q == ssd_scan_pkg::ST_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
		if (tick_beat) begin
			out_sel_q <= scan_idx_q;
			out_seg_q <= seg_buf_q[scan_idx_q];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ssd_scan_pkg::OUT_W - IDX_W - 8){1'b0}}, out_seg_q, out_sel_q};

endmodule
